// File: rtl/ncm_pkg.sv
// ncm_pkg: shared types, constants and helpers for the nearest color table match
// used by nearest_color_table_match and the testbench; no dependencies
`timescale 1ns / 1ps

package ncm_pkg;

  // table geometry
  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  // field widths
  localparam int unsigned ColorW = 16;
  localparam int unsigned SigmaW = 16;
  localparam int unsigned DistW  = ColorW + 2;
  localparam int unsigned CfgW   = 9;

  // memory word widths
  localparam int unsigned ColorWordW = 3 * ColorW;
  localparam int unsigned SigmaWordW = 6 * SigmaW;

  // configuration port
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic [PaddrW-1:0] RegEntriesInUse = 3'd0;

  // request function codes
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_OUT
  } state_e;

  // absolute difference of two color components
  function automatic logic [ColorW-1:0] abs_diff(input logic [ColorW-1:0] a,
                                                 input logic [ColorW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: rtl/nearest_color_table_match.sv
// nearest_color_table_match: L1 nearest-color search over a table of reference colors
// depends on ncm_pkg and ncm_ram (color memory and absorption memory)
`timescale 1ns / 1ps

//  channel   direction  handshake                 payload
//  in        in         in_valid_i / in_ready_o   func, entry_index, color, sigma triples, layer
//  out       out        out_valid_o / out_ready_i sigma triple, best_index, distance, error
//  apb       in         psel/penable/pwrite       paddr, pwdata, prdata (entries_in_use)
//
//  a load is written into both memories at the accept edge
//  a query with n entries in use reads the color memory entry by entry, compares the last
//  entry, closes the scan, reads the absorption memory and registers the result; the
//  sequencer registers the result as it returns to idle, where it takes the next request
//  with no entries in use a query skips the scan and the error result is registered from the output state
//  reset clears control state and entries_in_use; table contents are unknown until loaded
//  a stalled result holds the sequencer in its output state; requests wait in idle

module nearest_color_table_match (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [7:0]                   entry_index_i,
  input  logic [15:0]                  red_i,
  input  logic [15:0]                  green_i,
  input  logic [15:0]                  blue_i,
  input  logic [15:0]                  outer_red_i,
  input  logic [15:0]                  outer_green_i,
  input  logic [15:0]                  outer_blue_i,
  input  logic [15:0]                  inner_red_i,
  input  logic [15:0]                  inner_green_i,
  input  logic [15:0]                  inner_blue_i,
  input  logic                         layer_select_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  sigma_red_o,
  output logic [15:0]                  sigma_green_o,
  output logic [15:0]                  sigma_blue_o,
  output logic [7:0]                   best_index_o,
  output logic [17:0]                  best_distance_o,
  output logic                         empty_error_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ncm_pkg::PaddrW-1:0]   paddr,
  input  logic [ncm_pkg::PdataW-1:0]   pwdata,
  output logic [ncm_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);

  import ncm_pkg::*;

  state_e state_q, state_d;

  logic [CfgW-1:0]   entries_q;
  logic [CntW-1:0]   n_q, n_d;
  logic [CntW-1:0]   cnt_q;
  logic              dv_q;
  logic [IdxW-1:0]   di_q;
  logic [IdxW-1:0]   best_idx_q;
  logic [DistW-1:0]  best_dist_q;
  logic [ColorW-1:0] qr_q, qg_q, qb_q;
  logic              layer_q;
  logic              empty_q;

  logic              out_valid_q;
  logic [SigmaW-1:0] out_r_q, out_g_q, out_b_q;
  logic [IdxW-1:0]   out_idx_q;
  logic [DistW-1:0]  out_dist_q;
  logic              out_err_q;

  logic              req_acc;
  logic              ld_we;
  logic              qry_acc;
  logic              col_re;
  logic              sig_re;
  logic              out_load;
  logic              scan_done;

  logic [ColorWordW-1:0] col_rdata;
  logic [SigmaWordW-1:0] sig_rdata;
  logic [DistW-1:0]      entry_dist;
  logic                  better;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (psel && penable && pwrite && paddr == RegEntriesInUse) begin
      entries_q <= pwdata[CfgW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == RegEntriesInUse) begin
      prdata = {{(PdataW-CfgW){1'b0}}, entries_q};
    end
  end

  // entry count saturated at the table depth
  always_comb begin
    if (CntW'(entries_q) > CntW'(TableDepth)) begin
      n_d = CntW'(TableDepth);
    end else begin
      n_d = CntW'(entries_q);
    end
  end

  // table memories; loads only land in idle while no scan reads
  ncm_ram #(
    .Width (ColorWordW),
    .Depth (TableDepth)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (entry_index_i),
    .wdata_i ({red_i, green_i, blue_i}),
    .re_i    (col_re),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (col_rdata)
  );

  ncm_ram #(
    .Width (SigmaWordW),
    .Depth (TableDepth)
  ) u_sigma_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (entry_index_i),
    .wdata_i ({outer_red_i, outer_green_i, outer_blue_i,
                inner_red_i, inner_green_i, inner_blue_i}),
    .re_i    (sig_re),
    .raddr_i (best_idx_q),
    .rdata_o (sig_rdata)
  );

  // L1 distance of the entry read last cycle
  assign entry_dist = DistW'(abs_diff(qr_q, col_rdata[3*ColorW-1:2*ColorW]))
                    + DistW'(abs_diff(qg_q, col_rdata[2*ColorW-1:ColorW]))
                    + DistW'(abs_diff(qb_q, col_rdata[ColorW-1:0]));
  assign better = dv_q && (di_q == '0 || entry_dist < best_dist_q);

  assign scan_done = (cnt_q == n_q) && !dv_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (qry_acc) begin
          state_d = (n_d == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    col_re     = 1'b0;
    sig_re     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_SCAN:  col_re     = (cnt_q < n_q);
      ST_FETCH: sig_re     = 1'b1;
      ST_OUT:   out_load   = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign req_acc = in_valid_i && in_ready_o;
  assign ld_we   = req_acc && (func_e'(func_i) == FUNC_LOAD);
  assign qry_acc = req_acc && (func_e'(func_i) == FUNC_QUERY);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q    <= col_re;
      if (qry_acc) begin
        cnt_q <= '0;
      end else if (col_re) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // query context and running best
  always_ff @(posedge clk_i) begin
    if (qry_acc) begin
      qr_q    <= red_i;
      qg_q    <= green_i;
      qb_q    <= blue_i;
      layer_q <= layer_select_i;
      n_q     <= n_d;
      empty_q <= (n_d == '0);
    end
    if (col_re) begin
      di_q <= cnt_q[IdxW-1:0];
    end
    if (better) begin
      best_idx_q  <= di_q;
      best_dist_q <= entry_dist;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_err_q <= empty_q;
      if (empty_q) begin
        out_r_q    <= '0;
        out_g_q    <= '0;
        out_b_q    <= '0;
        out_idx_q  <= '0;
        out_dist_q <= '0;
      end else begin
        if (layer_q) begin
          out_r_q <= sig_rdata[6*SigmaW-1:5*SigmaW];
          out_g_q <= sig_rdata[5*SigmaW-1:4*SigmaW];
          out_b_q <= sig_rdata[4*SigmaW-1:3*SigmaW];
        end else begin
          out_r_q <= sig_rdata[3*SigmaW-1:2*SigmaW];
          out_g_q <= sig_rdata[2*SigmaW-1:SigmaW];
          out_b_q <= sig_rdata[SigmaW-1:0];
        end
        out_idx_q  <= best_idx_q;
        out_dist_q <= best_dist_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sigma_red_o     = out_r_q;
  assign sigma_green_o   = out_g_q;
  assign sigma_blue_o    = out_b_q;
  assign best_index_o    = out_idx_q;
  assign best_distance_o = out_dist_q;
  assign empty_error_o   = out_err_q;

  // loads never overlap a read of either table memory
  a_no_load_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_we |-> !col_re && !sig_re)
    else $error("table write during a query");

  // the kept entry lies inside the searched range
  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FETCH |-> CntW'(best_idx_q) < n_q)
    else $error("best index outside entries in use");

  // a fresh result only leaves the output state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside output state");

  // an error result carries zero fields
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_error_o |-> best_distance_o == '0 && best_index_o == '0
      && sigma_red_o == '0 && sigma_green_o == '0 && sigma_blue_o == '0)
    else $error("error result with nonzero fields");

endmodule

// File: rtl/ncm_ram.sv
// ncm_ram: generic single-write, single-read synchronous RAM, registered read
// no dependencies
`timescale 1ns / 1ps

module ncm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/ncm_tb_pkg.sv
// ncm_tb_pkg: request and match types plus the match tracker for the nearest color testbench
// depends on ncm_pkg for widths, table depth and function codes
`timescale 1ns / 1ps

package ncm_tb_pkg;

  import ncm_pkg::*;

  // layer select values of a query
  localparam logic LayerOuter = 1'b1;
  localparam logic LayerInner = 1'b0;

  // one request as driven on the input channel
  typedef struct packed {
    func_e             func;
    logic [IdxW-1:0]   entry_index;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic [SigmaW-1:0] outer_red;
    logic [SigmaW-1:0] outer_green;
    logic [SigmaW-1:0] outer_blue;
    logic [SigmaW-1:0] inner_red;
    logic [SigmaW-1:0] inner_green;
    logic [SigmaW-1:0] inner_blue;
    logic              layer_select;
  } request_t;

  // one match result as seen on the output channel
  typedef struct packed {
    logic [SigmaW-1:0] sigma_red;
    logic [SigmaW-1:0] sigma_green;
    logic [SigmaW-1:0] sigma_blue;
    logic [IdxW-1:0]   best_index;
    logic [DistW-1:0]  best_distance;
    logic              empty_error;
  } match_t;

  class color_match_tracker;
    // shadow table, red in the top bits of each word
    logic [3*ColorW-1:0] ref_color   [TableDepth];
    logic [3*SigmaW-1:0] outer_sigma [TableDepth];
    logic [3*SigmaW-1:0] inner_sigma [TableDepth];
    int unsigned         entry_count;
    match_t              expected_matches[$];
    int unsigned         mismatches;

    function new();
      entry_count = 0;
      mismatches  = 0;
    endfunction

    // register write, counts above the table depth saturate
    function void set_entry_count(logic [CfgW-1:0] value);
      entry_count = (value > TableDepth) ? TableDepth : value;
    endfunction

    function int unsigned pending();
      return expected_matches.size();
    endfunction

    // accepted request: update the table or predict the nearest match
    function void note_request(request_t r);
      match_t              m;
      logic [3*ColorW-1:0] q;
      int unsigned         a, b, d, best, best_d;
      if (r.func == FUNC_LOAD) begin
        ref_color[r.entry_index]   = {r.red, r.green, r.blue};
        outer_sigma[r.entry_index] = {r.outer_red, r.outer_green, r.outer_blue};
        inner_sigma[r.entry_index] = {r.inner_red, r.inner_green, r.inner_blue};
        return;
      end
      m = '0;
      if (entry_count == 0) begin
        m.empty_error = 1'b1;
      end else begin
        q      = {r.red, r.green, r.blue};
        best   = 0;
        best_d = 0;
        // l1 scan, only a strictly smaller sum replaces the kept entry
        for (int i = 0; i < entry_count; i++) begin
          d = 0;
          for (int k = 0; k < 3; k++) begin
            a = q[ColorW*(2-k) +: ColorW];
            b = ref_color[i][ColorW*(2-k) +: ColorW];
            d += (a > b) ? a - b : b - a;
          end
          if (i == 0 || d < best_d) begin
            best_d = d;
            best   = i;
          end
        end
        {m.sigma_red, m.sigma_green, m.sigma_blue} =
          (r.layer_select == LayerOuter) ? outer_sigma[best] : inner_sigma[best];
        m.best_index    = IdxW'(best);
        m.best_distance = DistW'(best_d);
      end
      expected_matches.push_back(m);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      end
    endfunction

    // accepted result against the oldest prediction
    function void check_result(match_t got);
      match_t want;
      if (expected_matches.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none got %h", $time, got);
        return;
      end
      want = expected_matches.pop_front();
      compare_field("sigma_red", 32'(want.sigma_red), 32'(got.sigma_red));
      compare_field("sigma_green", 32'(want.sigma_green), 32'(got.sigma_green));
      compare_field("sigma_blue", 32'(want.sigma_blue), 32'(got.sigma_blue));
      compare_field("best_index", 32'(want.best_index), 32'(got.best_index));
      compare_field("best_distance", 32'(want.best_distance), 32'(got.best_distance));
      compare_field("empty_error", 32'(want.empty_error), 32'(got.empty_error));
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// tb_top: drives loads, queries and register writes into nearest_color_table_match
// depends on ncm_pkg, ncm_tb_pkg and the block under test
`timescale 1ns / 1ps

module tb_top;

  import ncm_pkg::*;
  import ncm_tb_pkg::*;

  localparam int unsigned FixedPhases  = 14;
  localparam int unsigned NumPhases    = 17;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned EndSettle    = 300;
  localparam int unsigned StuckLimit   = 4000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                func_i;
  logic [7:0]          entry_index_i;
  logic [15:0]         red_i, green_i, blue_i;
  logic [15:0]         outer_red_i, outer_green_i, outer_blue_i;
  logic [15:0]         inner_red_i, inner_green_i, inner_blue_i;
  logic                layer_select_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [15:0]         sigma_red_o, sigma_green_o, sigma_blue_o;
  logic [7:0]          best_index_o;
  logic [17:0]         best_distance_o;
  logic                empty_error_o;
  logic                psel, penable, pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [PdataW-1:0]   pwdata;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  color_match_tracker  tracker;
  int                  send_calm;
  int                  sink_calm;
  int unsigned         readback_errors;
  int unsigned         stuck_cycles;
  bit                  stall_results;

  nearest_color_table_match dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .entry_index_i   (entry_index_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .outer_red_i     (outer_red_i),
    .outer_green_i   (outer_green_i),
    .outer_blue_i    (outer_blue_i),
    .inner_red_i     (inner_red_i),
    .inner_green_i   (inner_green_i),
    .inner_blue_i    (inner_blue_i),
    .layer_select_i  (layer_select_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sigma_red_o     (sigma_red_o),
    .sigma_green_o   (sigma_green_o),
    .sigma_blue_o    (sigma_blue_o),
    .best_index_o    (best_index_o),
    .best_distance_o (best_distance_o),
    .empty_error_o   (empty_error_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // idle cycles before the next handshake, with runs of back-to-back traffic
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  // color component biased toward extremes and a coarse grid so ties occur
  function automatic logic [ColorW-1:0] pick_component();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return ColorW'(16'h8000);
      3, 4: return ColorW'($urandom_range(0, 15) * 16'h1111);
      default: return ColorW'($urandom_range(0, 65535));
    endcase
  endfunction

  // load request with random content in every field but the function code
  function automatic request_t random_request();
    request_t r;
    r.func         = FUNC_LOAD;
    r.entry_index  = IdxW'($urandom_range(0, TableDepth - 1));
    r.red          = pick_component();
    r.green        = pick_component();
    r.blue         = pick_component();
    r.outer_red    = SigmaW'($urandom_range(0, 65535));
    r.outer_green  = SigmaW'($urandom_range(0, 65535));
    r.outer_blue   = SigmaW'($urandom_range(0, 65535));
    r.inner_red    = SigmaW'($urandom_range(0, 65535));
    r.inner_green  = SigmaW'($urandom_range(0, 65535));
    r.inner_blue   = SigmaW'($urandom_range(0, 65535));
    r.layer_select = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // offer one request and hold it until accepted
  task automatic send_request(input request_t r);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= r.func;
    entry_index_i  <= r.entry_index;
    red_i          <= r.red;
    green_i        <= r.green;
    blue_i         <= r.blue;
    outer_red_i    <= r.outer_red;
    outer_green_i  <= r.outer_green;
    outer_blue_i   <= r.outer_blue;
    inner_red_i    <= r.inner_red;
    inner_green_i  <= r.inner_green;
    inner_blue_i   <= r.inner_blue;
    layer_select_i <= r.layer_select;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(r);
  endtask

  task automatic load_entry(input logic [IdxW-1:0] idx, input logic [3*ColorW-1:0] color,
                            input logic [3*SigmaW-1:0] outer, input logic [3*SigmaW-1:0] inner);
    request_t r;
    r = random_request();
    r.entry_index = idx;
    {r.red, r.green, r.blue} = color;
    {r.outer_red, r.outer_green, r.outer_blue} = outer;
    {r.inner_red, r.inner_green, r.inner_blue} = inner;
    send_request(r);
  endtask

  // query carries junk in the load-only fields
  task automatic query_color(input logic [3*ColorW-1:0] color, input logic layer);
    request_t r;
    r = random_request();
    r.func = FUNC_QUERY;
    {r.red, r.green, r.blue} = color;
    r.layer_select = layer;
    send_request(r);
  endtask

  // stop offering until every result is back, then let the block settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write followed by a read back
  task automatic write_entries(input logic [PdataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegEntriesInUse;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_entry_count(value[CfgW-1:0]);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CfgW-1:0] !== value[CfgW-1:0]) begin
      readback_errors++;
      $display("%0t: entries_in_use read expected %0h got %0h", $time, value[CfgW-1:0],
               prdata[CfgW-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result sink with random stalls and one long hold-off on request
  initial begin : result_sink
    int gap;
    sink_calm = 0;
    @(posedge rst_ni);
    forever begin
      if (stall_results) begin
        stall_results = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      gap = draw_gap(sink_calm);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_result({sigma_red_o, sigma_green_o, sigma_blue_o, best_index_o,
                            best_distance_o, empty_error_o});
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == StuckLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    request_t            r;
    int                  n_eff, count, mode, j;
    logic [PdataW-1:0]   cfg_word;
    logic [3*ColorW-1:0] color;
    logic [PdataW-1:0]   phase_cfg [FixedPhases];

    phase_cfg = '{32'd2, 32'd8, 32'd1, 32'd32, 32'd256, 32'd5, 32'd511, 32'd16,
                  32'hA5A5_A403, 32'd64, 32'd0, 32'd300, 32'd3, 32'd12};
    tracker         = new();
    send_calm       = 0;
    readback_errors = 0;
    stuck_cycles    = 0;
    stall_results   = 1'b0;

    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    func_i         <= FUNC_LOAD;
    entry_index_i  <= '0;
    red_i          <= '0;
    green_i        <= '0;
    blue_i         <= '0;
    outer_red_i    <= '0;
    outer_green_i  <= '0;
    outer_blue_i   <= '0;
    inner_red_i    <= '0;
    inner_green_i  <= '0;
    inner_blue_i   <= '0;
    layer_select_i <= LayerInner;
    out_ready_i    <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table gives the error result
    write_entries(32'd0);
    query_color('0, LayerInner);
    query_color('1, LayerOuter);

    // extremes, a duplicate color for the tie, and a mixed entry
    load_entry(8'd0, '0, '1, '0);
    load_entry(8'd1, '1, 48'h0100_0200_0300, '1);
    load_entry(8'd2, '1, 48'hAAAA_5555_0F0F, 48'h5555_AAAA_F0F0);
    load_entry(8'd3, 48'h8000_1234_ABCD, 48'h0001_8000_7FFF, 48'hFFFE_0000_1111);
    wait_drained();

    // single entry: largest distance and exact hit
    write_entries(32'd1);
    query_color('1, LayerOuter);
    query_color('0, LayerInner);
    wait_drained();

    // tie goes to the lower index
    write_entries(32'd4);
    query_color('1, LayerInner);
    query_color('1, LayerOuter);
    query_color({3{16'h7FFF}}, LayerOuter);
    query_color(48'h8000_1234_ABCD, LayerOuter);
    query_color(48'h8001_1233_ABCD, LayerInner);
    wait_drained();

    // fill the whole table so any count is legal
    for (int e = 0; e < TableDepth; e++) begin
      r = random_request();
      r.entry_index = IdxW'(e);
      send_request(r);
    end

    // random phases, each under its own entry count
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      cfg_word = (p < FixedPhases) ? phase_cfg[p] : PdataW'($urandom_range(1, 48));
      write_entries(cfg_word);
      n_eff = tracker.entry_count;
      count = (n_eff >= 128) ? 36 : 95;
      for (int i = 0; i < count; i++) begin
        if (p == 1 && i == 20) stall_results = 1'b1;
        if (i == 55) wait_drained();
        if ($urandom_range(0, 9) < 3) begin
          send_request(random_request());
        end else begin
          mode = $urandom_range(0, 2);
          j = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
          for (int k = 0; k < 3; k++) begin
            if (mode == 0)
              color[ColorW*(2-k) +: ColorW] = ColorW'($urandom_range(0, 65535));
            else if (mode == 1 && n_eff > 0)
              color[ColorW*(2-k) +: ColorW] = tracker.ref_color[j][ColorW*(2-k) +: ColorW]
                                              + ColorW'($urandom_range(0, 6)) - ColorW'(3);
            else
              color[ColorW*(2-k) +: ColorW] = pick_component();
          end
          query_color(color, 1'($urandom_range(0, 1)));
        end
      end
    end

    wait_drained();
    repeat (EndSettle) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0 && readback_errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
